// ----- sv/crlf_framed_key_value_parser_defines.svh -----
// Assertion macros for the CRLF key/value parser RTL.
// Needs a clock named clk and a reset named rst in the using module.
`ifndef CRLF_FRAMED_KEY_VALUE_PARSER_DEFINES_SVH
`define CRLF_FRAMED_KEY_VALUE_PARSER_DEFINES_SVH

// checked only outside reset
`define CRLF_KVP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define CRLF_KVP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/crlf_kvp_pkg.sv -----
// Package for the CRLF key/value parser: characters, codes, limits and types.
// No dependencies.
`timescale 1ns / 1ps
package crlf_kvp_pkg;

  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [6:0] MAX_COMMAND = 7'd64;
  localparam logic [6:0] NAME_CAP    = 7'd65;
  localparam logic [6:0] VALUE_CAP   = 7'd65;

  localparam logic [2:0] K_NAME  = 3'd0;
  localparam logic [2:0] K_VALUE = 3'd1;
  localparam logic [2:0] K_PAIR  = 3'd2;
  localparam logic [2:0] K_ERROR = 3'd3;
  localparam logic [2:0] K_END   = 3'd4;

  localparam logic [1:0] PH_NAME  = 2'd0;
  localparam logic [1:0] PH_SKIP  = 2'd1;
  localparam logic [1:0] PH_VALUE = 2'd2;
  localparam logic [1:0] PH_LF    = 2'd3;

  localparam int RESQ_DEPTH = 4;
  localparam int RESQ_CW    = $clog2(RESQ_DEPTH + 1);
  localparam int RESQ_AW    = $clog2(RESQ_DEPTH);

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] out_byte;
    logic       last;
  } res_t;

  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } step_out_t;

endpackage

// ----- sv/crlf_kvp_step.sv -----
// Lookahead window, framing and parse state; produces up to two results per byte.
// Depends on crlf_kvp_pkg.
`timescale 1ns / 1ps
module crlf_kvp_step (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   accept,
  input  logic [7:0]             data_byte,
  input  logic                   restart,
  output crlf_kvp_pkg::step_out_t res
);
  import crlf_kvp_pkg::*;

  logic [7:0] win0, win1, win2;
  logic [7:0] win0_next, win1_next, win2_next;
  logic [1:0] fill, fill_next;
  logic [1:0] phase, phase_next;
  logic [6:0] flen, flen_next;
  logic [6:0] mlen, mlen_next;
  logic       err, err_next;

  always_comb begin
    logic       term;
    logic       em;
    logic [2:0] ek;
    logic [7:0] eb;
    logic [7:0] c;
    win0_next  = win0;
    win1_next  = win1;
    win2_next  = win2;
    fill_next  = fill;
    phase_next = phase;
    flen_next  = flen;
    mlen_next  = mlen;
    err_next   = err;
    res        = '0;
    em         = 1'b0;
    ek         = K_NAME;
    eb         = 8'd0;
    c          = win0;
    term = (fill == 2'd3) && (win0 == CH_CR) && (win1 == CH_LF) && (win2 == CH_CR) &&
           (data_byte == CH_LF);
    if (accept) begin
      if (restart) begin
        win0_next  = '0;
        win1_next  = '0;
        win2_next  = '0;
        fill_next  = '0;
        phase_next = PH_NAME;
        flen_next  = '0;
        mlen_next  = '0;
        err_next   = 1'b0;
      end else if (term) begin
        if (!err && phase == PH_VALUE) begin
          res.n  = 2'd2;
          res.r0 = '{kind: (flen >= VALUE_CAP) ? K_ERROR : K_PAIR, out_byte: 8'd0,
                     last: 1'b0};
          res.r1 = '{kind: K_END, out_byte: 8'd0, last: 1'b1};
        end else begin
          res.n  = 2'd1;
          res.r0 = '{kind: K_END, out_byte: 8'd0, last: 1'b1};
        end
        win0_next  = '0;
        win1_next  = '0;
        win2_next  = '0;
        fill_next  = '0;
        phase_next = PH_NAME;
        flen_next  = '0;
        mlen_next  = '0;
        err_next   = 1'b0;
      end else if (fill != 2'd3) begin
        unique case (fill)
          2'd0:    win0_next = data_byte;
          2'd1:    win1_next = data_byte;
          default: win2_next = data_byte;
        endcase
        fill_next = fill + 2'd1;
      end else begin
        win0_next = win1;
        win1_next = win2;
        win2_next = data_byte;
        if (mlen < MAX_COMMAND) begin
          mlen_next = mlen + 7'd1;
          if (!err) begin
            unique case (phase)
              PH_NAME: begin
                if (c != CH_CR && c != CH_LF) begin
                  if (flen >= NAME_CAP) begin
                    em = 1'b1;
                    ek = K_ERROR;
                  end else if (c == CH_COLON) begin
                    phase_next = PH_SKIP;
                    flen_next  = '0;
                  end else begin
                    flen_next = flen + 7'd1;
                    em = 1'b1;
                    ek = K_NAME;
                    eb = c;
                  end
                end
              end
              PH_SKIP: begin
                if (c != CH_SPACE) begin
                  if (flen >= VALUE_CAP) begin
                    em = 1'b1;
                    ek = K_ERROR;
                  end else begin
                    flen_next  = flen + 7'd1;
                    phase_next = PH_VALUE;
                    em = 1'b1;
                    ek = K_VALUE;
                    eb = c;
                  end
                end
              end
              PH_VALUE: begin
                if (flen >= VALUE_CAP) begin
                  em = 1'b1;
                  ek = K_ERROR;
                end else if (c == CH_CR) begin
                  phase_next = PH_LF;
                  em = 1'b1;
                  ek = K_PAIR;
                end else begin
                  flen_next = flen + 7'd1;
                  em = 1'b1;
                  ek = K_VALUE;
                  eb = c;
                end
              end
              default: begin
                if (c != CH_LF) begin
                  em = 1'b1;
                  ek = K_ERROR;
                end else begin
                  phase_next = PH_NAME;
                  flen_next  = '0;
                end
              end
            endcase
            if (em) begin
              res.n  = 2'd1;
              res.r0 = '{kind: ek, out_byte: eb, last: 1'b1};
              if (ek == K_ERROR) begin
                err_next = 1'b1;
              end
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win0  <= '0;
      win1  <= '0;
      win2  <= '0;
      fill  <= '0;
      phase <= PH_NAME;
      flen  <= '0;
      mlen  <= '0;
      err   <= 1'b0;
    end else begin
      win0  <= win0_next;
      win1  <= win1_next;
      win2  <= win2_next;
      fill  <= fill_next;
      phase <= phase_next;
      flen  <= flen_next;
      mlen  <= mlen_next;
      err   <= err_next;
    end
  end

endmodule

// ----- sv/crlf_kvp_resq.sv -----
// Result queue: takes up to two results per cycle, hands out one per transaction.
// Depends on crlf_kvp_pkg and the assertion macros.
`timescale 1ns / 1ps
`include "crlf_framed_key_value_parser_defines.svh"
module crlf_kvp_resq (
  input  logic                    clk,
  input  logic                    rst,
  input  crlf_kvp_pkg::step_out_t push,
  output logic                    room,
  output logic                    result_valid,
  input  logic                    result_stall,
  output crlf_kvp_pkg::res_t      head
);
  import crlf_kvp_pkg::*;

  res_t               q [RESQ_DEPTH];
  res_t               q_next [RESQ_DEPTH];
  logic [RESQ_CW-1:0] count, count_next;
  logic               pop;
  logic [RESQ_CW-1:0] base;

  assign pop          = result_valid && !result_stall;
  assign result_valid = (count != '0);
  assign room         = (count <= RESQ_CW'(RESQ_DEPTH - 2));
  assign head         = q[0];
  assign base         = count - RESQ_CW'(pop);

  always_comb begin
    for (int i = 0; i < RESQ_DEPTH; i++) begin
      q_next[i] = q[i];
    end
    if (pop) begin
      for (int i = 0; i < RESQ_DEPTH - 1; i++) begin
        q_next[i] = q[i + 1];
      end
    end
    for (int i = 0; i < RESQ_DEPTH; i++) begin
      if (push.n != 2'd0 && RESQ_CW'(i) == base) begin
        q_next[i] = push.r0;
      end
      if (push.n == 2'd2 && RESQ_CW'(i) == base + RESQ_CW'(1)) begin
        q_next[i] = push.r1;
      end
    end
    count_next = base + RESQ_CW'(push.n);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < RESQ_DEPTH; i++) begin
      q[i] <= q_next[i];
    end
  end

  `CRLF_KVP_ASSERT(a_count_bound, count <= RESQ_CW'(RESQ_DEPTH), "result queue overfilled")
  `CRLF_KVP_ASSERT(a_push_room, (push.n != 2'd0) |-> room, "results pushed without room")
  `CRLF_KVP_ASSERT(a_push_visible, (count == '0 && push.n != 2'd0) |=> result_valid, "result lost")
  `CRLF_KVP_ASSERT(a_no_triple, push.n != 2'd3, "more than two results from one byte")

endmodule

// ----- sv/crlf_framed_key_value_parser.sv -----
// Top level of the CRLF framed key/value parser: step logic feeding a result queue.
// Depends on crlf_kvp_pkg, crlf_kvp_step and crlf_kvp_resq.
`timescale 1ns / 1ps
// Takes one byte of a session stream per cycle while byte_stall is low and emits
// name bytes, value bytes, pair-complete, error and message-end results, one per
// output transaction. A byte is taken whenever the four-entry result queue has two
// free slots, so with an output that does not stall the input runs at one byte
// per clock; results produced when a byte is taken are registered in the queue.
// Only the byte that completes a CR LF CR LF terminator can produce two results,
// and the queue absorbs the extra one. Results of a byte appear three bytes later,
// after the lookahead window; a restart byte clears step state, yielding nothing.
module crlf_framed_key_value_parser (
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  output logic       byte_stall,
  input  logic [7:0] data_byte,
  input  logic       restart,
  output logic       result_valid,
  input  logic       result_stall,
  output logic [2:0] kind,
  output logic [7:0] out_byte,
  output logic       last
);
  import crlf_kvp_pkg::*;

  logic      accept;
  logic      room;
  step_out_t step_res;
  res_t      head;

  assign byte_stall = !room;
  assign accept     = byte_valid && room;

  crlf_kvp_step u_step (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .data_byte (data_byte),
    .restart   (restart),
    .res       (step_res)
  );

  crlf_kvp_resq u_resq (
    .clk          (clk),
    .rst          (rst),
    .push         (step_res),
    .room         (room),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .head         (head)
  );

  assign kind     = head.kind;
  assign out_byte = head.out_byte;
  assign last     = head.last;

endmodule
